// ----- src/htok_pkg.sv -----
// ----------------------------------------------------------------------------
// htok_pkg
// Types, grammar phases and literal tables for the request line tokenizer.
// ----------------------------------------------------------------------------
package htok_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] echo_byte;
    logic [1:0] token_class;
    logic       pair_start;
    logic       line_ok;
    logic       line_bad;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_METHOD      = 4'd0,
    PH_URL_FIRST   = 4'd1,
    PH_URL         = 4'd2,
    PH_KEY_FIRST   = 4'd3,
    PH_KEY         = 4'd4,
    PH_VALUE_FIRST = 4'd5,
    PH_VALUE       = 4'd6,
    PH_TRAILER     = 4'd7,
    PH_DONE        = 4'd8
  } phase_t;

  localparam logic [1:0] CLS_SYNTAX = 2'd0;
  localparam logic [1:0] CLS_URL    = 2'd1;
  localparam logic [1:0] CLS_KEY    = 2'd2;
  localparam logic [1:0] CLS_VALUE  = 2'd3;

  localparam logic [3:0] METHOD_LEN  = 4'd4;
  localparam logic [3:0] TRAILER_LEN = 4'd11;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUERY = 8'h3f;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQUAL = 8'h3d;

  // "GET "
  function automatic logic [7:0] method_char(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h54;
      default: c = CH_SPACE;
    endcase
    return c;
  endfunction

  // " HTTP/1.1" CR LF
  function automatic logic [7:0] trailer_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = CH_SPACE;
      4'd1:    c = 8'h48;
      4'd2:    c = 8'h54;
      4'd3:    c = 8'h54;
      4'd4:    c = 8'h50;
      4'd5:    c = 8'h2f;
      4'd6:    c = 8'h31;
      4'd7:    c = 8'h2e;
      4'd8:    c = 8'h31;
      4'd9:    c = 8'h0d;
      4'd10:   c = 8'h0a;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- src/htok_in_stage.sv -----
// ----------------------------------------------------------------------------
// htok_in_stage
// Input register: holds one request until the tokenizer step takes it.
// ----------------------------------------------------------------------------
module htok_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  htok_pkg::in_item_t in_item,
  output logic               q_valid,
  output htok_pkg::in_item_t q_item,
  input  logic               take
);

  // register frees up in the same cycle it is drained
  assign in_stall = q_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      q_item <= in_item;
    end
  end

endmodule

// ----- src/htok_step.sv -----
// ----------------------------------------------------------------------------
// htok_step
// Grammar state, per-byte classification and the result register.
// ----------------------------------------------------------------------------
module htok_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  htok_pkg::in_item_t  q_item,
  output logic                take,
  output logic                out_valid,
  input  logic                out_stall,
  output htok_pkg::out_item_t out_item
);

  htok_pkg::phase_t    phase, phase_next;
  logic [3:0]          literal_index, literal_index_next;
  logic                failed, failed_next;
  htok_pkg::out_item_t res;

  logic [7:0] b;
  logic       err;
  logic [1:0] cls;
  logic       ps;
  logic       ok;

  assign take = q_valid && (!out_valid || !out_stall);
  assign b    = q_item.data_byte;

  always_comb begin
    phase_next         = phase;
    literal_index_next = literal_index;
    failed_next        = failed;
    err                = 1'b0;
    cls                = htok_pkg::CLS_SYNTAX;
    ps                 = 1'b0;
    ok                 = 1'b0;

    if (!failed) begin
      case (phase)
        htok_pkg::PH_METHOD: begin
          if (literal_index < htok_pkg::METHOD_LEN &&
              b == htok_pkg::method_char(literal_index[1:0])) begin
            if (literal_index == htok_pkg::METHOD_LEN - 4'd1) begin
              phase_next         = htok_pkg::PH_URL_FIRST;
              literal_index_next = 4'd0;
            end else begin
              literal_index_next = literal_index + 4'd1;
            end
          end else begin
            err = 1'b1;
          end
        end
        htok_pkg::PH_URL_FIRST: begin
          if (b == htok_pkg::CH_SPACE || b == htok_pkg::CH_QUERY ||
              b == htok_pkg::CH_AMP) begin
            err = 1'b1;
          end else begin
            cls        = htok_pkg::CLS_URL;
            phase_next = htok_pkg::PH_URL;
          end
        end
        htok_pkg::PH_URL: begin
          if (b == htok_pkg::CH_SPACE) begin
            phase_next         = htok_pkg::PH_TRAILER;
            literal_index_next = 4'd1;
          end else if (b == htok_pkg::CH_QUERY) begin
            phase_next = htok_pkg::PH_KEY_FIRST;
          end else if (b == htok_pkg::CH_AMP) begin
            err = 1'b1;
          end else begin
            cls = htok_pkg::CLS_URL;
          end
        end
        htok_pkg::PH_KEY_FIRST: begin
          if (b == htok_pkg::CH_SPACE || b == htok_pkg::CH_AMP ||
              b == htok_pkg::CH_EQUAL) begin
            err = 1'b1;
          end else begin
            cls        = htok_pkg::CLS_KEY;
            ps         = 1'b1;
            phase_next = htok_pkg::PH_KEY;
          end
        end
        htok_pkg::PH_KEY: begin
          if (b == htok_pkg::CH_EQUAL) begin
            phase_next = htok_pkg::PH_VALUE_FIRST;
          end else if (b == htok_pkg::CH_AMP) begin
            phase_next = htok_pkg::PH_KEY_FIRST;
          end else if (b == htok_pkg::CH_SPACE) begin
            phase_next         = htok_pkg::PH_TRAILER;
            literal_index_next = 4'd1;
          end else begin
            cls = htok_pkg::CLS_KEY;
          end
        end
        htok_pkg::PH_VALUE_FIRST: begin
          // empty value is not allowed
          if (b == htok_pkg::CH_SPACE || b == htok_pkg::CH_AMP) begin
            err = 1'b1;
          end else begin
            cls        = htok_pkg::CLS_VALUE;
            phase_next = htok_pkg::PH_VALUE;
          end
        end
        htok_pkg::PH_VALUE: begin
          if (b == htok_pkg::CH_AMP) begin
            phase_next = htok_pkg::PH_KEY_FIRST;
          end else if (b == htok_pkg::CH_SPACE) begin
            phase_next         = htok_pkg::PH_TRAILER;
            literal_index_next = 4'd1;
          end else begin
            cls = htok_pkg::CLS_VALUE;
          end
        end
        htok_pkg::PH_TRAILER: begin
          if (literal_index < htok_pkg::TRAILER_LEN &&
              b == htok_pkg::trailer_char(literal_index)) begin
            if (literal_index == htok_pkg::TRAILER_LEN - 4'd1) begin
              phase_next         = htok_pkg::PH_DONE;
              literal_index_next = 4'd0;
            end else begin
              literal_index_next = literal_index + 4'd1;
            end
          end else begin
            err = 1'b1;
          end
        end
        default: begin
          // anything after the line feed, or a stray code
          err = 1'b1;
        end
      endcase
      if (err) begin
        failed_next = 1'b1;
        cls         = htok_pkg::CLS_SYNTAX;
        ps          = 1'b0;
      end
    end

    if (q_item.line_end) begin
      ok = !failed_next && (phase_next == htok_pkg::PH_DONE);
      if (!ok) begin
        cls = htok_pkg::CLS_SYNTAX;
        ps  = 1'b0;
      end
      res.line_bad       = !ok;
      phase_next         = htok_pkg::PH_METHOD;
      literal_index_next = 4'd0;
      failed_next        = 1'b0;
    end else begin
      res.line_bad = failed_next;
    end

    res.echo_byte   = b;
    res.token_class = cls;
    res.pair_start  = ps;
    res.line_ok     = ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= htok_pkg::PH_METHOD;
      literal_index <= 4'd0;
      failed        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        phase         <= phase_next;
        literal_index <= literal_index_next;
        failed        <= failed_next;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item <= res;
    end
  end

endmodule

// ----- src/http_request_line_tokenizer.sv -----
// ----------------------------------------------------------------------------
// http_request_line_tokenizer
// Tags each byte of a GET request line and reports the line's verdict.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one byte of the request line per request, line_end set on the
//           last byte. out_* : one result per input byte, same order.
//   Each result echoes the byte with its class (syntax, url, key, value),
//   pair_start on the first key byte, line_ok or line_bad on the last byte;
//   line_bad stays set from the first offending byte to the end of the line.
//   out_valid rises once the byte held in the input register is taken:
//   the grammar step and the result register sit behind it, so the result
//   is registered, and out_stall can hold the byte in the input register.
//   Throughput is one byte per cycle while out_stall is low, bounded by the
//   single grammar state update per byte.
//   When out_stall is high the result holds; an empty input register still
//   takes one more byte, and once it is full in_stall stays high until the
//   result is taken.
//   Synchronous reset empties both registers and returns the grammar to the
//   start of a line; the last byte of every line also returns the grammar there.
// ----------------------------------------------------------------------------
module http_request_line_tokenizer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  htok_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output htok_pkg::out_item_t out_item
);

  logic               q_valid;
  htok_pkg::in_item_t q_item;
  logic               take;

  htok_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .take     (take)
  );

  htok_step u_step (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
